@@ hw/rtl/utf8v_pkg.sv @@
// Shared types and constants of the UTF-8 stream validator.
// No dependencies; used by the front, queue, back and top level files.
package utf8v_pkg;

    // Default depth of the queue between the front and back parts (power of two, >= 2).
    localparam int unsigned QUEUE_DEPTH = 2;

    // Byte class as decided by the front part, independent of sequence state.
    typedef enum logic [2:0] {
        CLS_NONE  = 3'd0,   // bare end marker, no byte
        CLS_ASCII = 3'd1,   // 00..7F
        CLS_CONT  = 3'd2,   // 80..BF
        CLS_LEAD2 = 3'd3,   // C2..DF
        CLS_LEAD3 = 3'd4,   // E0..EF
        CLS_LEAD4 = 3'd5,   // F0..F4
        CLS_BAD   = 3'd6    // C0, C1, F5..FF
    } t_cls;

    // One classified transaction as it travels through the queue.
    typedef struct packed {
        t_cls       cls;
        logic [5:0] bits;   // payload bits, lead mask already applied
        logic       last;   // end of string
    } t_item;

endpackage

@@ hw/rtl/utf8v_front.sv @@
// Front part: accepts input transactions, classifies the byte, holds it in a register.
// Depends on utf8v_pkg.
module utf8v_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_byte_present,
    input  logic                i_end_of_string,
    output logic                o_push,
    output utf8v_pkg::t_item    o_item,
    input  logic                i_full
);

    logic             r_valid;
    logic             n_valid;
    utf8v_pkg::t_item r_item;
    utf8v_pkg::t_item n_item;
    utf8v_pkg::t_item cls_item;

    always_comb begin
        cls_item.last = i_end_of_string;
        cls_item.bits = i_data_byte[5:0];
        if (!i_byte_present) begin
            cls_item.cls = utf8v_pkg::CLS_NONE;
        end else if (i_data_byte <= 8'h7F) begin
            cls_item.cls = utf8v_pkg::CLS_ASCII;
        end else if (i_data_byte <= 8'hBF) begin
            cls_item.cls = utf8v_pkg::CLS_CONT;
        end else if (i_data_byte < 8'hC2) begin
            cls_item.cls = utf8v_pkg::CLS_BAD;
        end else if (i_data_byte <= 8'hDF) begin
            cls_item.cls  = utf8v_pkg::CLS_LEAD2;
            cls_item.bits = {1'b0, i_data_byte[4:0]};
        end else if (i_data_byte <= 8'hEF) begin
            cls_item.cls  = utf8v_pkg::CLS_LEAD3;
            cls_item.bits = {2'b00, i_data_byte[3:0]};
        end else if (i_data_byte <= 8'hF4) begin
            cls_item.cls  = utf8v_pkg::CLS_LEAD4;
            cls_item.bits = {3'b000, i_data_byte[2:0]};
        end else begin
            cls_item.cls = utf8v_pkg::CLS_BAD;
        end
    end

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (o_ready) begin
            n_valid = i_valid;
            n_item  = cls_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

@@ hw/rtl/utf8v_queue.sv @@
// Small FIFO of classified transactions between the front and back parts.
// Depends on utf8v_pkg.
module utf8v_queue #(
    parameter int unsigned DEPTH = utf8v_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  utf8v_pkg::t_item    i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output utf8v_pkg::t_item    o_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    utf8v_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ hw/rtl/utf8v_back.sv @@
// Back part: runs the UTF-8 sequence state and drives the verdict output register.
// Depends on utf8v_pkg.
module utf8v_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  utf8v_pkg::t_item    i_q_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_string_valid
);

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    logic [1:0]  r_pend;
    logic [2:0]  r_len;
    logic [20:0] r_code;
    logic        r_err;
    logic        r_out_valid;
    logic        r_out_data;
    logic [1:0]  n_pend;
    logic [2:0]  n_len;
    logic [20:0] n_code;
    logic        n_err;
    logic        n_out_valid;
    logic        n_out_data;

    logic        out_free;
    logic [20:0] code_acc;
    logic [1:0]  pend_dec;
    logic        range_bad;

    assign out_free = !r_out_valid || i_ready;
    // Non-final transactions never touch the output slot and drain freely.
    assign o_pop    = i_q_valid && (!i_q_item.last || out_free);

    assign code_acc = {r_code[14:0], i_q_item.bits};
    assign pend_dec = r_pend - 2'd1;

    always_comb begin
        range_bad = 1'b0;
        if (r_len == SEQ_LEN3) begin
            range_bad = (code_acc[20:11] == 10'h000) || (code_acc[20:11] == 10'h01B);
        end else if (r_len == SEQ_LEN4) begin
            range_bad = (code_acc[20:16] == 5'h00) || (code_acc > 21'h10FFFF);
        end
    end

    always_comb begin
        n_pend      = r_pend;
        n_len       = r_len;
        n_code      = r_code;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        if (o_pop) begin
            unique case (i_q_item.cls)
                utf8v_pkg::CLS_NONE: begin
                end
                utf8v_pkg::CLS_ASCII: begin
                    if (r_pend != 2'd0) begin
                        n_err  = 1'b1;
                        n_pend = 2'd0;
                        n_len  = SEQ_NONE;
                        n_code = '0;
                    end
                end
                utf8v_pkg::CLS_LEAD2, utf8v_pkg::CLS_LEAD3, utf8v_pkg::CLS_LEAD4: begin
                    if (r_pend != 2'd0) begin
                        n_err  = 1'b1;
                        n_pend = 2'd0;
                        n_len  = SEQ_NONE;
                        n_code = '0;
                    end else begin
                        n_code = {15'd0, i_q_item.bits};
                        if (i_q_item.cls == utf8v_pkg::CLS_LEAD2) begin
                            n_pend = 2'd1;
                            n_len  = SEQ_LEN2;
                        end else if (i_q_item.cls == utf8v_pkg::CLS_LEAD3) begin
                            n_pend = 2'd2;
                            n_len  = SEQ_LEN3;
                        end else begin
                            n_pend = 2'd3;
                            n_len  = SEQ_LEN4;
                        end
                    end
                end
                utf8v_pkg::CLS_CONT: begin
                    if (r_pend == 2'd0) begin
                        n_err  = 1'b1;
                        n_len  = SEQ_NONE;
                        n_code = '0;
                    end else if (pend_dec != 2'd0) begin
                        n_pend = pend_dec;
                        n_code = code_acc;
                    end else begin
                        n_pend = 2'd0;
                        n_err  = r_err || range_bad;
                        n_len  = SEQ_NONE;
                        n_code = '0;
                    end
                end
                default: begin
                    // lead not allowed anywhere
                    n_err  = 1'b1;
                    n_pend = 2'd0;
                    n_len  = SEQ_NONE;
                    n_code = '0;
                end
            endcase
            if (i_q_item.last) begin
                n_out_valid = 1'b1;
                n_out_data  = !n_err && (n_pend == 2'd0);
                n_pend      = 2'd0;
                n_len       = SEQ_NONE;
                n_code      = '0;
                n_err       = 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_string_valid = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 2'd0;
            r_len       <= SEQ_NONE;
            r_code      <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_len       <= n_len;
            r_code      <= n_code;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

endmodule

@@ hw/rtl/utf8_stream_validator.sv @@
// Top level of the UTF-8 stream validator: front classifier, queue, back state unit.
// Depends on utf8v_pkg, utf8v_front, utf8v_queue and utf8v_back.

// Checks a byte string for well-formed UTF-8 (RFC 3629), one byte per input
// transaction, and returns one verdict transaction for each end-of-string
// transaction. A transaction with i_byte_present low carries no byte; with
// i_end_of_string low as well it is an idle transaction that changes nothing.
// Throughput is one transaction per clock cycle, sustained, in both
// directions, while i_ready stays high; the limit is the update of the
// sequence state in the back unit. An accepted end-of-string transaction
// reaches o_valid through the front register, the queue and the output
// register. The front keeps taking bytes while a verdict waits in the output
// register: only end-of-string transactions wait for the output slot, and
// the queue (QUEUE_DEPTH entries) absorbs the difference. Overlong,
// surrogate and out-of-range sequences, bad leads, bad continuations and
// truncated strings all give o_string_valid low; an empty string gives high.
// After each verdict the state returns to reset, so the next transaction
// starts a new string.
module utf8_stream_validator #(
    parameter int unsigned QUEUE_DEPTH = utf8v_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_string,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_string_valid
);

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    utf8v_pkg::t_item front_item;
    utf8v_pkg::t_item q_item;

    // Classify each byte; stalls only when the queue is full.
    utf8v_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_end_of_string(i_end_of_string),
        .o_push         (push),
        .o_item         (front_item),
        .i_full         (q_full)
    );

    utf8v_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Sequence state, sticky error and the verdict register.
    utf8v_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_string_valid (o_string_valid)
    );

endmodule

@@ hw/rtl/utf8v_checker.sv @@
// Port-level assertions for the UTF-8 stream validator, bound to the top level.
// Depends on utf8_stream_validator's port list only.
module utf8v_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        i_end_of_string,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic        o_string_valid
);

    // End-of-string transactions taken in but not yet answered.
    logic [7:0] r_open_ends;
    logic       in_end;
    logic       out_take;

    assign in_end   = i_valid && o_ready && i_end_of_string;
    assign out_take = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_ends <= '0;
        end else if (in_end && !out_take) begin
            r_open_ends <= r_open_ends + 8'd1;
        end else if (out_take && !in_end) begin
            r_open_ends <= r_open_ends - 8'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("verdict dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_string_valid))
        else $error("verdict changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("verdict shown right after reset");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_open_ends != 8'd0)
        else $error("verdict without an end-of-string transaction");

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_end_of_string(i_end_of_string),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_string_valid (o_string_valid)
);

@@ bench/testbench.sv @@
// Self-checking bench for utf8_stream_validator: directed and random byte strings.
// Depends on the RTL of the block and its package; predicts each verdict in place.
module testbench;

    // Code-point limits that decide a well-formed three- or four-byte sequence.
    localparam logic [20:0] MIN_3BYTE = 21'h000800;
    localparam logic [20:0] MIN_4BYTE = 21'h010000;
    localparam logic [20:0] MAX_CODE  = 21'h10FFFF;
    // Bits 20..11 of a code point in D800..DFFF.
    localparam logic [9:0]  SURROGATE_TAG = 10'h01B;

    // Stop when this many cycles pass with no transaction on either side.
    localparam int STALL_LIMIT = 1000;
    // Non-idle input transactions in the random part.
    localparam int RANDOM_ITEMS = 1600;
    // Code points at the encoding boundaries.
    localparam int unsigned EDGE_CPS [10] = '{
        'h0, 'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hE000, 'hFFFF, 'h10000, 'h10FFFF
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_byte_present = 1'b0;
    logic       i_end_of_string = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic       o_string_valid;

    utf8_stream_validator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_byte_present  (i_byte_present),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_string_valid  (o_string_valid)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Verdict predictor: decoder state of the string now being checked.
    // ------------------------------------------------------------------
    logic [1:0]  cont_left;     // continuation bytes still owed
    logic [2:0]  seq_bytes;     // length of the open sequence, 0 if none
    logic [20:0] code_acc;      // code point bits gathered so far
    logic        err_sticky;    // sticky until the verdict

    bit          verdict_q[$];  // predicted verdicts, oldest first
    logic [7:0]  text_bytes[$]; // string being built for the next send

    int          mismatch_count = 0;
    int          items_sent = 0;
    int          stall_cycles = 0;
    bit          steady_send = 1'b0;  // no sender gaps while set

    function automatic void clear_decoder();
        cont_left = 2'd0;
        seq_bytes = 3'd0;
        code_acc = 21'd0;
    endfunction

    // Bad lead or bad continuation: flag it and abandon the open sequence.
    function automatic void drop_sequence();
        err_sticky = 1'b1;
        clear_decoder();
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        if (cont_left == 2'd0) begin
            if (b > 8'h7F) begin
                if (b >= 8'hC2 && b <= 8'hDF) begin
                    cont_left = 2'd1;
                    seq_bytes = 3'd2;
                    code_acc = {16'd0, b[4:0]};
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    cont_left = 2'd2;
                    seq_bytes = 3'd3;
                    code_acc = {17'd0, b[3:0]};
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    cont_left = 2'd3;
                    seq_bytes = 3'd4;
                    code_acc = {18'd0, b[2:0]};
                end else begin
                    drop_sequence();
                end
            end
        end else if (b[7:6] != 2'b10) begin
            // the offending byte is not taken as a new lead
            drop_sequence();
        end else begin
            code_acc = {code_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                if (seq_bytes == 3'd3
                        && (code_acc < MIN_3BYTE || code_acc[20:11] == SURROGATE_TAG))
                    err_sticky = 1'b1;
                else if (seq_bytes == 3'd4 && (code_acc < MIN_4BYTE || code_acc > MAX_CODE))
                    err_sticky = 1'b1;
                seq_bytes = 3'd0;
                code_acc = 21'd0;
            end
        end
    endfunction

    // Called once per accepted input transaction.
    function automatic void predict_item(input logic [7:0] b, input bit present,
                                         input bit is_end);
        if (present)
            absorb_byte(b);
        if (is_end) begin
            // truncated string counts as ill-formed
            verdict_q.insert(verdict_q.size(), !err_sticky && cont_left == 2'd0);
            clear_decoder();
            err_sticky = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random ready, verdict check, watchdog.
    // Everything is sampled on the falling edge, away from the rising
    // edge where inputs change, so no race with the block's flops.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Ready runs in segments: short open stretches, sometimes long ones, short stalls, rare long stalls.
    initial begin
        int run;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 1) == 1) begin
                i_ready <= 1'b1;
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(1, 12);
            end else begin
                i_ready <= 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(1, 3);
            end
            repeat (run - 1) @(posedge i_clk);
        end
    end

    // The verdict transaction completes at the next rising edge.
    initial begin
        bit want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("verdict %b with no string pending",
                                              o_string_valid));
                end else begin
                    want = verdict_q.pop_front();
                    if (o_string_valid !== want)
                        report_mismatch($sformatf("string_valid %b, expected %b",
                                                  o_string_valid, want));
                end
            end
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Send side.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_send || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Valid stays high after the transaction; the next call either lowers it
    // for a gap or replaces the payload in the same step.
    task automatic send_item(input logic [7:0] b, input bit present, input bit is_end);
        int gap;
        bit took;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_byte_present <= present;
        i_end_of_string <= is_end;
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
        predict_item(b, present, is_end);
        if (present || is_end)
            items_sent++;
    endtask

    // Sender holds off until every predicted verdict has come back.
    task automatic wait_for_verdicts();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Sends text_bytes as one string; the end marker rides on the last byte
    // or comes as a bare end transaction. Idle transactions are sprinkled in.
    task automatic send_text(input bit bare_end);
        int n;
        n = text_bytes.size();
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(text_bytes[k], 1'b1, (k == n - 1) && !bare_end);
        end
        if (bare_end || n == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // String builders.
    // ------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endfunction

    function automatic int natural_len(input int unsigned cp);
        if (cp < 'h80)
            return 1;
        if (cp < 'h800)
            return 2;
        if (cp < 'h10000)
            return 3;
        return 4;
    endfunction

    // Encodes cp in len bytes whether or not that length is the right one,
    // which is how overlong and out-of-range forms are made.
    function automatic void push_encoded(input int unsigned cp, input int len);
        case (len)
            1: add_byte(cp[7:0]);
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void push_code_point(input int unsigned cp);
        push_encoded(cp, natural_len(cp));
    endfunction

    // Any scalar value, spread over the four encoding lengths.
    function automatic int unsigned pick_code_point();
        int unsigned cp;
        case ($urandom_range(0, 9))
            0, 1, 2: cp = $urandom_range(0, 'h7F);
            3, 4:    cp = $urandom_range('h80, 'h7FF);
            5, 6: begin
                // skip the surrogate block
                cp = $urandom_range('h800, 'hF7FF);
                if (cp >= 'hD800)
                    cp += 'h800;
            end
            7, 8:    cp = $urandom_range('h10000, 'h10FFFF);
            default: cp = EDGE_CPS[$urandom_range(0, 9)];
        endcase
        return cp;
    endfunction

    // Spoils a well-formed string in one of several ways; a random byte may leave it well-formed.
    function automatic void spoil_text();
        int unsigned cp;
        int len;
        int pos;
        pos = $urandom_range(0, text_bytes.size());
        case ($urandom_range(0, 6))
            0: text_bytes.insert(pos, 8'($urandom_range(0, 255)));
            1: begin
                // overlong: a small value in a longer form
                len = $urandom_range(2, 4);
                cp = (len == 2) ? $urandom_range(0, 'h7F)
                   : (len == 3) ? $urandom_range(0, 'h7FF) : $urandom_range(0, 'hFFFF);
                push_encoded(cp, len);
            end
            2: push_encoded($urandom_range('hD800, 'hDFFF), 3);
            3: push_encoded($urandom_range('h110000, 'h1FFFFF), 4);
            4: begin
                // truncated sequence, maybe followed by a byte that is not a continuation
                cp = $urandom_range('h80, 'h10FFFF);
                if (cp >= 'hD800 && cp <= 'hDFFF)
                    cp = 'hE000;
                len = natural_len(cp);
                push_encoded(cp, len);
                repeat ($urandom_range(1, len - 1))
                    void'(text_bytes.pop_back());
                if ($urandom_range(0, 1) == 1)
                    push_code_point(pick_code_point());
            end
            5: text_bytes.insert(pos, 8'($urandom_range('h80, 'hBF)));
            default: begin
                text_bytes.delete();
                repeat ($urandom_range(1, 8))
                    add_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    function automatic void build_text();
        int units;
        text_bytes.delete();
        units = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
        repeat (units)
            push_code_point(pick_code_point());
        if ($urandom_range(0, 9) < 3)
            spoil_text();
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    task automatic test_empty_and_idle();
        text_bytes.delete();
        send_text(1'b1);                        // empty string
        send_item(8'hFF, 1'b0, 1'b0);           // idle, payload ignored
        text_bytes = '{8'h7F};
        send_text(1'b0);
    endtask

    task automatic test_bad_bytes();
        text_bytes = '{8'h00, 8'hFF};           // bad lead sticks to the end
        send_text(1'b0);
        text_bytes = '{8'hC2, 8'h41};           // bad continuation, not re-read
        send_text(1'b0);
    endtask

    task automatic test_sequence_limits();
        text_bytes = '{8'hDF, 8'hBF};           // top of the two-byte range
        send_text(1'b0);
        text_bytes = '{8'hE0, 8'h9F, 8'hBF};    // overlong three-byte
        send_text(1'b0);
        text_bytes = '{8'hED, 8'hA0, 8'h80};    // surrogate
        send_text(1'b0);
        text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; // above 10FFFF
        send_text(1'b0);
    endtask

    task automatic test_truncated_string();
        text_bytes = '{8'hF0, 8'h90, 8'h80};
        send_text(1'b1);
    endtask

    // Back-to-back strings at full rate, then a pause until all verdicts return.
    task automatic test_full_rate_and_drain();
        steady_send = 1'b1;
        repeat (6) begin
            build_text();
            send_text($urandom_range(0, 1) == 1);
        end
        steady_send = 1'b0;
        wait_for_verdicts();
    endtask

    task automatic test_random_text();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            steady_send = ($urandom_range(0, 5) == 0);
            build_text();
            send_text($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0)
                wait_for_verdicts();
        end
        steady_send = 1'b0;
    endtask

    initial begin
        clear_decoder();
        err_sticky = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_idle();
        test_bad_bytes();
        test_sequence_limits();
        test_truncated_string();
        test_full_rate_and_drain();
        test_random_text();

        wait_for_verdicts();
        // keep the clock running to catch stray verdicts
        repeat (8) @(posedge i_clk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d verdicts never came", verdict_q.size()));
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
